FILE: rtl/core/multi_channel_pulse_width_capture_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-channel pulse width capture block
// Clocked on aclk, held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PULSE_WIDTH_CAPTURE_MACROS_SVH
`define MULTI_CHANNEL_PULSE_WIDTH_CAPTURE_MACROS_SVH

// Check that an expression holds at every clock edge.
`define MCPWC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define MCPWC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mcpwc_pkg.sv
// ----------------------------------------------------------------------------
// mcpwc_pkg
// Shared constants and register codes for the pulse width capture block.
// ----------------------------------------------------------------------------
package mcpwc_pkg;

    localparam int unsigned CHANNELS_DEFAULT    = 8;
    localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
    localparam int unsigned QUEUE_DEPTH         = 4;

    localparam int unsigned TOP_RESET    = 49999;
    localparam int unsigned ENABLE_RESET = 255;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_TIMER_TOP      = 1'b0,
        REG_CHANNEL_ENABLE = 1'b1
    } reg_index_t;

endpackage

FILE: rtl/core/multi_channel_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// multi_channel_pulse_width_capture
// Edge-timed pulse width measurement over several pulse inputs at once.
// ----------------------------------------------------------------------------
// Each input item carries one sample of the pulse input levels together with
// the free-running timer count. Levels are masked with channel_enable and
// compared with the previous sample by one lane per channel, all in parallel.
// A rising edge stores the timer count as the channel's start time; a falling
// edge yields one result item holding the channel number and the high time in
// ticks, corrected for one wrap of the timer past timer_top (the width is
// timer_top + 1 - start + now when now is below start). Results of one input
// item leave in ascending channel order, and tlast marks the final one of
// them. Disabling a channel that is high counts as its falling edge; enabling
// a channel that is high counts as its rising edge. Rate: one input item per
// clock while the DEPTH-entry result queue (four by default) has room; the
// output drains one result per clock while m_tready is high, and the queue
// depth sets how far a burst of edges can run ahead of the output. A result
// is written to a queue entry when its item is taken, then loaded into the
// output register behind m_tvalid. Control state clears in the same cycle as
// reset, but not queue storage or output data; no clearing pass follows.
// Registers (APB, word aligned): 0x0 timer_top, 0x4 channel_enable.
// ----------------------------------------------------------------------------
module multi_channel_pulse_width_capture #(
    parameter int unsigned CHANNELS    = mcpwc_pkg::CHANNELS_DEFAULT,
    parameter int unsigned COUNT_WIDTH = mcpwc_pkg::COUNT_WIDTH_DEFAULT,
    parameter int unsigned DEPTH       = mcpwc_pkg::QUEUE_DEPTH,
    localparam int unsigned CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int unsigned S_DATA_W   = ((CHANNELS + COUNT_WIDTH + 7) / 8) * 8,
    localparam int unsigned M_DATA_W   = ((CH_W + COUNT_WIDTH + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // pin_levels, timer_count, zero pad
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // channel, pulse_width, zero pad
    output logic                m_tlast,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [COUNT_WIDTH-1:0] timer_top_reg, timer_top_next;
    logic [CHANNELS-1:0]    enable_reg, enable_next;

    mcpwc_pkg::reg_index_t  reg_index;
    logic                   cfg_write;

    logic                                 accept;
    logic [CHANNELS-1:0]                  pin_levels;
    logic [COUNT_WIDTH-1:0]               timer_count;
    logic [CHANNELS-1:0]                  fall_mask;
    logic [CHANNELS-1:0][COUNT_WIDTH-1:0] widths;

    logic [CH_W-1:0]        out_channel;
    logic [COUNT_WIDTH-1:0] out_width;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_index = mcpwc_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        timer_top_next = timer_top_reg;
        enable_next    = enable_reg;
        if (cfg_write) begin
            unique case (reg_index)
                mcpwc_pkg::REG_TIMER_TOP:      timer_top_next = pwdata[COUNT_WIDTH-1:0];
                mcpwc_pkg::REG_CHANNEL_ENABLE: enable_next    = pwdata[CHANNELS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            mcpwc_pkg::REG_TIMER_TOP:      prdata = 32'(timer_top_reg);
            mcpwc_pkg::REG_CHANNEL_ENABLE: prdata = 32'(enable_reg);
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_top_reg <= COUNT_WIDTH'(mcpwc_pkg::TOP_RESET);
            enable_reg    <= CHANNELS'(mcpwc_pkg::ENABLE_RESET);
        end else begin
            timer_top_reg <= timer_top_next;
            enable_reg    <= enable_next;
        end
    end

    // ---------------- per-channel lanes ----------------
    assign accept      = s_tvalid && s_tready;
    assign pin_levels  = s_tdata[CHANNELS-1:0];
    assign timer_count = s_tdata[CHANNELS+COUNT_WIDTH-1:CHANNELS];

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        mcpwc_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .accept    (accept),
            .level_in  (pin_levels[g]),
            .enable    (enable_reg[g]),
            .now       (timer_count),
            .timer_top (timer_top_reg),
            .fall      (fall_mask[g]),
            .width     (widths[g])
        );
    end

    // ---------------- merge and drain ----------------
    mcpwc_queue #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .DEPTH       (DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .fall_mask   (fall_mask),
        .widths      (widths),
        .in_ready    (s_tready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_channel (out_channel),
        .out_width   (out_width),
        .out_last    (m_tlast)
    );

    // pack channel in the low bits, width above, zero pad on top
    assign m_tdata = M_DATA_W'({out_width, out_channel});

endmodule

FILE: rtl/core/mcpwc_lane.sv
// ----------------------------------------------------------------------------
// mcpwc_lane
// One channel: edge detect, start time capture and wrap-corrected width.
// ----------------------------------------------------------------------------
module mcpwc_lane #(
    parameter int unsigned COUNT_WIDTH = mcpwc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   level_in,
    input  logic                   enable,
    input  logic [COUNT_WIDTH-1:0] now,
    input  logic [COUNT_WIDTH-1:0] timer_top,
    output logic                   fall,
    output logic [COUNT_WIDTH-1:0] width
);

    logic                   level;
    logic                   prev_reg;
    logic                   prev_next;
    logic [COUNT_WIDTH-1:0] rise_reg;
    logic [COUNT_WIDTH-1:0] rise_next;
    logic [COUNT_WIDTH-1:0] diff;
    logic [COUNT_WIDTH-1:0] wrap_add;

    assign level = level_in & enable;
    assign fall  = accept & prev_reg & ~level;

    // width = now - start, plus a full period when the timer wrapped
    assign diff     = now - rise_reg;
    assign wrap_add = (now < rise_reg) ? (timer_top + COUNT_WIDTH'(1)) : '0;
    assign width    = diff + wrap_add;

    always_comb begin
        prev_next = prev_reg;
        rise_next = rise_reg;
        if (accept) begin
            prev_next = level;
            if (level && !prev_reg) begin
                rise_next = now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= 1'b0;
            rise_reg <= '0;
        end else begin
            prev_reg <= prev_next;
            rise_reg <= rise_next;
        end
    end

endmodule

FILE: rtl/core/mcpwc_queue.sv
// ----------------------------------------------------------------------------
// mcpwc_queue
// Queue each item's lane results; drain one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "multi_channel_pulse_width_capture_macros.svh"

module mcpwc_queue #(
    parameter int unsigned CHANNELS    = mcpwc_pkg::CHANNELS_DEFAULT,
    parameter int unsigned COUNT_WIDTH = mcpwc_pkg::COUNT_WIDTH_DEFAULT,
    parameter int unsigned DEPTH       = mcpwc_pkg::QUEUE_DEPTH,
    localparam int unsigned CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 accept,
    input  logic [CHANNELS-1:0]                  fall_mask,
    input  logic [CHANNELS-1:0][COUNT_WIDTH-1:0] widths,
    output logic                                 in_ready,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [CH_W-1:0]                      out_channel,
    output logic [COUNT_WIDTH-1:0]               out_width,
    output logic                                 out_last
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CHANNELS-1:0]                  mask_mem  [DEPTH];
    logic [CHANNELS-1:0][COUNT_WIDTH-1:0] width_mem [DEPTH];

    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   started_reg, started_next;
    logic [CHANNELS-1:0]    rem_mask_reg, rem_mask_next;
    logic                   valid_reg, valid_next;
    logic [CH_W-1:0]        channel_reg;
    logic [COUNT_WIDTH-1:0] width_reg;
    logic                   last_reg;

    logic                   push;
    logic                   pop;
    logic                   load;
    logic [CHANNELS-1:0]    work_mask;
    logic [CHANNELS-1:0]    rest_mask;
    logic [CH_W-1:0]        pick;

    // items without a falling edge leave nothing to report
    assign push     = accept && (fall_mask != '0);
    assign in_ready = (count_reg < CNT_W'(DEPTH));

    assign work_mask = started_reg ? rem_mask_reg : mask_mem[rd_ptr_reg];
    assign rest_mask = work_mask & (work_mask - CHANNELS'(1));
    assign load      = (count_reg != '0) && (!valid_reg || out_ready);
    assign pop       = load && (rest_mask == '0);

    // lowest pending channel goes first
    always_comb begin
        pick = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (work_mask[i]) begin
                pick = CH_W'(i);
            end
        end
    end

    // pointers wrap at the last entry, so any depth works
    always_comb begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                             : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                             : rd_ptr_reg + PTR_W'(1);
        end
        count_next    = count_reg + CNT_W'(push) - CNT_W'(pop);
        started_next  = load ? (rest_mask != '0) : started_reg;
        rem_mask_next = load ? rest_mask : rem_mask_reg;
        valid_next    = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            started_reg  <= 1'b0;
            rem_mask_reg <= '0;
            valid_reg    <= 1'b0;
        end else begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
            started_reg  <= started_next;
            rem_mask_reg <= rem_mask_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mask_mem[wr_ptr_reg]  <= fall_mask;
            width_mem[wr_ptr_reg] <= widths;
        end
        if (load) begin
            channel_reg <= pick;
            width_reg   <= width_mem[rd_ptr_reg][pick];
            last_reg    <= (rest_mask == '0);
        end
    end

    assign out_valid   = valid_reg;
    assign out_channel = channel_reg;
    assign out_width   = width_reg;
    assign out_last    = last_reg;

    `MCPWC_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count exceeds depth")
    `MCPWC_ASSERT_IMPL(a_started_nonempty, started_reg, count_reg != '0, "draining an empty queue")
    `MCPWC_ASSERT_IMPL(a_load_pending, load, work_mask != '0, "head entry has no pending channel")
    `MCPWC_ASSERT_IMPL(a_push_space, push, in_ready, "push into a full queue")

endmodule
